@@ design/sliding_window_threshold_ratio_defines.svh @@
// Assertion macros used by the sliding window threshold ratio sequencer.
`ifndef SLIDING_WINDOW_THRESHOLD_RATIO_DEFINES_SVH
`define SLIDING_WINDOW_THRESHOLD_RATIO_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWTR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swtr check failed");

// next-cycle implication, disabled during reset
`define SWTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swtr check failed");

`endif

@@ design/swtr_pkg.sv @@
// Shared constants and types for the sliding window threshold ratio block.
package swtr_pkg;

    localparam int MAX_WINDOW     = 64;
    localparam int VALUE_BITS     = 16;
    localparam int SLOT_BITS      = $clog2(MAX_WINDOW);
    localparam int COUNT_BITS     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS       = VALUE_BITS + SLOT_BITS;
    localparam int MULT_BITS      = 8;
    localparam int THR_BITS       = SUM_BITS + MULT_BITS;
    localparam int LHS_BITS       = VALUE_BITS + COUNT_BITS + 4;
    localparam int CMP_BITS       = (THR_BITS > LHS_BITS) ? THR_BITS : LHS_BITS;
    localparam int TOTAL_BITS     = 24;
    localparam int FIELD_CNT_BITS = 7;
    localparam int WF_BITS        = 7;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_FRAMES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THR_MULT      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BELOW_MODE    = 2'd2;

    localparam logic [WF_BITS-1:0]   WF_RESET   = 7'd64;
    localparam logic [MULT_BITS-1:0] MULT_RESET = 8'd8;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic shift;
        logic load;
    } chain_ctrl_t;

endpackage

@@ design/sliding_window_threshold_ratio.sv @@
// Top level: sliding window threshold ratio (LSTER / HZCRR) over a rotating cell chain.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  frame     | frame_valid / frame_ready  | feature_value, clip_start
//  result    | result_valid / result_ready| window_positive, window_count,
//            |                            | current_passes, clip_positive_total,
//            |                            | clip_frame_total
//  config    | cfg_we                     | cfg_index, cfg_data
//
// For each request the chain rotates once to sum the window and once more to compare
// each entry with the threshold.
// frame_ready is high only while no request is in flight; a finished result waits in
// the output register while the next request is taken.
// A stalled result_ready holds the sequencer at its last step until the register frees.
// Reset clears fill level, clip totals and control; cell contents need no reset.
module sliding_window_threshold_ratio (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 frame_valid,
    output logic                                 frame_ready,
    input  logic [swtr_pkg::VALUE_BITS-1:0]      feature_value,
    input  logic                                 clip_start,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [swtr_pkg::FIELD_CNT_BITS-1:0]  window_positive,
    output logic [swtr_pkg::FIELD_CNT_BITS-1:0]  window_count,
    output logic                                 current_passes,
    output logic [swtr_pkg::TOTAL_BITS-1:0]      clip_positive_total,
    output logic [swtr_pkg::TOTAL_BITS-1:0]      clip_frame_total,
    input  logic                                 cfg_we,
    input  logic [swtr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [swtr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import swtr_pkg::*;

    chain_ctrl_t chain_ctrl;
    value_t      cell_in  [MAX_WINDOW];
    value_t      cell_out [MAX_WINDOW];

    // load the new value at the head, otherwise rotate the tail back in
    assign cell_in[0] = chain_ctrl.load ? feature_value : cell_out[MAX_WINDOW-1];

    genvar gi;
    generate
        for (gi = 1; gi < MAX_WINDOW; gi++)
        begin : g_link
            assign cell_in[gi] = cell_out[gi-1];
        end
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            swtr_cell u_cell (
                .clk      (clk),
                .shift    (chain_ctrl.shift),
                .data_in  (cell_in[gi]),
                .data_out (cell_out[gi])
            );
        end
    endgenerate

    swtr_seq u_seq (
        .clk                 (clk),
        .rst_n               (rst_n),
        .frame_valid         (frame_valid),
        .frame_ready         (frame_ready),
        .feature_value       (feature_value),
        .clip_start          (clip_start),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .window_positive     (window_positive),
        .window_count        (window_count),
        .current_passes      (current_passes),
        .clip_positive_total (clip_positive_total),
        .clip_frame_total    (clip_frame_total),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .tail                (cell_out[MAX_WINDOW-1]),
        .chain_ctrl          (chain_ctrl)
    );

endmodule

@@ design/swtr_cell.sv @@
// One window cell: holds a feature value and passes it to its neighbor.
module swtr_cell (
    input  logic            clk,
    input  logic            shift,
    input  swtr_pkg::value_t data_in,
    output swtr_pkg::value_t data_out
);
    import swtr_pkg::*;

    value_t value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= data_in;
        end
    end

    assign data_out = value_reg;

endmodule

@@ design/swtr_seq.sv @@
// Sequencer: configuration, window sum and compare passes, clip totals, result register.
`include "sliding_window_threshold_ratio_defines.svh"

module swtr_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 frame_valid,
    output logic                                 frame_ready,
    input  swtr_pkg::value_t                     feature_value,
    input  logic                                 clip_start,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [swtr_pkg::FIELD_CNT_BITS-1:0]  window_positive,
    output logic [swtr_pkg::FIELD_CNT_BITS-1:0]  window_count,
    output logic                                 current_passes,
    output logic [swtr_pkg::TOTAL_BITS-1:0]      clip_positive_total,
    output logic [swtr_pkg::TOTAL_BITS-1:0]      clip_frame_total,
    input  logic                                 cfg_we,
    input  logic [swtr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [swtr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  swtr_pkg::value_t                     tail,
    output swtr_pkg::chain_ctrl_t                chain_ctrl
);
    import swtr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_THR  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [SLOT_BITS-1:0]  LAST_STEP = SLOT_BITS'(MAX_WINDOW - 1);
    localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_WINDOW);
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    logic [2:0]              state_reg, state_next;
    logic [SLOT_BITS-1:0]    step_reg;
    logic [WF_BITS-1:0]      window_frames_reg;
    logic [MULT_BITS-1:0]    mult_reg;
    logic                    below_mode_reg;
    logic [COUNT_BITS-1:0]   fill_reg, fill_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [THR_BITS-1:0]     thr_reg;
    logic [COUNT_BITS-1:0]   positive_reg;
    logic                    cur_reg;
    logic [TOTAL_BITS-1:0]   clip_passes_reg, clip_frames_reg;
    logic [TOTAL_BITS-1:0]   clip_passes_next, clip_frames_next;
    logic                    result_valid_reg;
    logic [FIELD_CNT_BITS-1:0] window_positive_reg, window_count_reg;
    logic                    current_passes_reg;
    logic [TOTAL_BITS-1:0]   clip_positive_total_reg, clip_frame_total_reg;

    logic                    accept;
    logic                    last_step;
    logic [SLOT_BITS-1:0]    age;
    logic                    in_window;
    logic [COUNT_BITS-1:0]   fill_base;
    logic [COUNT_BITS-1:0]   w_clamp;
    logic [LHS_BITS-1:0]     lhs;
    logic                    pass;
    logic                    out_free;

    assign frame_ready = (state_reg == S_IDLE);
    assign accept      = frame_valid && frame_ready;
    assign last_step   = (step_reg == LAST_STEP);
    assign age         = LAST_STEP - step_reg;
    assign in_window   = (COUNT_BITS'(age) < count_reg);
    assign out_free    = !result_valid_reg || result_ready;

    assign chain_ctrl.load  = accept;
    assign chain_ctrl.shift = accept || (state_reg == S_SUM) || (state_reg == S_CMP);

    always_comb
    begin
        if (window_frames_reg == '0)
        begin
            w_clamp = COUNT_BITS'(1);
        end
        else if (32'(window_frames_reg) > 32'(MAX_WINDOW))
        begin
            w_clamp = MAX_COUNT;
        end
        else
        begin
            w_clamp = COUNT_BITS'(window_frames_reg);
        end
        fill_base  = clip_start ? '0 : fill_reg;
        fill_next  = (fill_base < MAX_COUNT) ? fill_base + COUNT_BITS'(1) : fill_base;
        count_next = (fill_next < w_clamp) ? fill_next : w_clamp;
    end

    always_comb
    begin
        lhs = (LHS_BITS'(tail) * LHS_BITS'(count_reg)) << 4;
        if (below_mode_reg)
        begin
            pass = (CMP_BITS'(lhs) < CMP_BITS'(thr_reg));
        end
        else
        begin
            pass = (CMP_BITS'(lhs) > CMP_BITS'(thr_reg));
        end
    end

    always_comb
    begin
        clip_frames_next = (clip_frames_reg != TOTAL_MAX) ? clip_frames_reg + 1'b1
                                                          : clip_frames_reg;
        clip_passes_next = clip_passes_reg;
        if (cur_reg && clip_passes_reg != TOTAL_MAX)
        begin
            clip_passes_next = clip_passes_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (last_step)
                begin
                    state_next = S_THR;
                end
            end
            S_THR:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (last_step)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            step_reg          <= '0;
            window_frames_reg <= WF_RESET;
            mult_reg          <= MULT_RESET;
            below_mode_reg    <= 1'b1;
            fill_reg          <= '0;
            clip_passes_reg   <= '0;
            clip_frames_reg   <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_FRAMES: window_frames_reg <= WF_BITS'(cfg_data);
                    CFG_THR_MULT:      mult_reg          <= cfg_data;
                    CFG_BELOW_MODE:    below_mode_reg    <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                fill_reg <= fill_next;
                step_reg <= '0;
                if (clip_start)
                begin
                    clip_passes_reg <= '0;
                    clip_frames_reg <= '0;
                end
            end
            else if (state_reg == S_SUM || state_reg == S_CMP)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == S_OUT && out_free)
            begin
                result_valid_reg <= 1'b1;
                clip_passes_reg  <= clip_passes_next;
                clip_frames_reg  <= clip_frames_next;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_reg    <= count_next;
            sum_reg      <= '0;
            positive_reg <= '0;
            cur_reg      <= 1'b0;
        end
        if (state_reg == S_SUM && in_window)
        begin
            sum_reg <= sum_reg + SUM_BITS'(tail);
        end
        if (state_reg == S_THR)
        begin
            thr_reg <= THR_BITS'(mult_reg) * THR_BITS'(sum_reg);
        end
        if (state_reg == S_CMP)
        begin
            if (in_window && pass)
            begin
                positive_reg <= positive_reg + 1'b1;
            end
            if (last_step)
            begin
                cur_reg <= pass;
            end
        end
        if (state_reg == S_OUT && out_free)
        begin
            window_positive_reg     <= FIELD_CNT_BITS'(positive_reg);
            window_count_reg        <= FIELD_CNT_BITS'(count_reg);
            current_passes_reg      <= cur_reg;
            clip_positive_total_reg <= clip_passes_next;
            clip_frame_total_reg    <= clip_frames_next;
        end
    end

    assign result_valid        = result_valid_reg;
    assign window_positive     = window_positive_reg;
    assign window_count        = window_count_reg;
    assign current_passes      = current_passes_reg;
    assign clip_positive_total = clip_positive_total_reg;
    assign clip_frame_total    = clip_frame_total_reg;

    `SWTR_ASSERT_NEXT(a_accept_starts_sum, accept, state_reg == S_SUM)
    `SWTR_ASSERT_NEXT(a_cmp_ends_in_out, (state_reg == S_CMP) && last_step, state_reg == S_OUT)
    `SWTR_ASSERT_NOW(a_count_in_range, state_reg == S_CMP, (count_reg != '0) && (count_reg <= MAX_COUNT))
    `SWTR_ASSERT_NOW(a_passes_le_frames, 1'b1, clip_passes_reg <= clip_frames_reg)

endmodule
